// ----- rtl/emcc_pkg.sv -----
package emcc_pkg;

  typedef enum logic [1:0] {
    OP_START     = 2'd0,
    OP_PATT_ROW  = 2'd1,
    OP_TARG_ROW  = 2'd2,
    OP_CHECK     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CAUSE_NONE         = 3'd0,
    CAUSE_FIRST        = 3'd1,
    CAUSE_SECOND       = 3'd2,
    CAUSE_PATTERN_EDGE = 3'd3,
    CAUSE_TARGET_EDGE  = 3'd4
  } cause_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_FIRST  = 2'd1,
    ST_SECOND = 2'd2
  } state_t;

  localparam int VertW   = 6;
  localparam int MapDepth = 64;
  localparam int RowW    = 64;

  typedef struct packed {
    op_t              op;
    logic [VertW-1:0] first_pattern;
    logic [VertW-1:0] second_pattern;
    logic [VertW-1:0] first_target;
    logic [VertW-1:0] second_target;
    logic [RowW-1:0]  row_bits;
  } in_t;

  typedef struct packed {
    logic       consistent;
    logic [2:0] failure_cause;
  } out_t;

endpackage

// ----- rtl/emcc_ram.sv -----
module emcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Registered read; data holds until the next read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/edge_mapping_consistency_checker_unit.sv -----
// Strobes: start, row writes and mapping requests after a latched failure
//   strobe in the cycle after acceptance; a live mapping request strobes after
//   ST_FIRST on a first endpoint conflict, else after ST_SECOND (map reads in turn).
// Throughput: one request per cycle for start and row writes while not busy; a live
//   mapping request holds busy until it strobes, so no new request is taken before then.
// Reset: synchronous active-low rst_n clears state, valid bits and the latch.
module edge_mapping_consistency_checker_unit
  import emcc_pkg::*;
#(
  parameter int PATTERN_VERTICES = 64,
  parameter int TARGET_VERTICES  = 64
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  in_t  in_item,
  output logic busy,
  output logic out_strobe,
  output out_t out_item
);

  localparam int PAW = $clog2(PATTERN_VERTICES);
  localparam int TAW = $clog2(TARGET_VERTICES);
  localparam int MAW = $clog2(MapDepth);

  // Control state
  state_t              state_r, state_nxt;
  cause_t              fail_r, fail_nxt;
  logic [MapDepth-1:0] valid_r, valid_nxt;
  logic                out_strobe_r, out_strobe_nxt;

  // Payload of the mapping request under work
  in_t item_r, item_nxt;

  // Map RAM port
  logic             map_we, map_re;
  logic [MAW-1:0]   map_waddr, map_raddr;
  logic [VertW-1:0] map_wdata, map_rdata;

  // Adjacency RAM ports
  logic                        prow_we, prow_re;
  logic [PAW-1:0]              prow_waddr, prow_raddr;
  logic [PATTERN_VERTICES-1:0] prow_wdata, prow_rdata;
  logic                        trow_we, trow_re;
  logic [TAW-1:0]              trow_waddr, trow_raddr;
  logic [TARGET_VERTICES-1:0]  trow_wdata, trow_rdata;

  logic             fp_in_range_p, fp_in_range_t;
  logic             p_edge, t_edge;
  logic [VertW-1:0] sp_bound;

  emcc_ram #(.WIDTH(VertW), .DEPTH(MapDepth)) u_map_ram (
    .clk  (clk),
    .we   (map_we),
    .waddr(map_waddr),
    .wdata(map_wdata),
    .re   (map_re),
    .raddr(map_raddr),
    .rdata(map_rdata)
  );

  emcc_ram #(.WIDTH(PATTERN_VERTICES), .DEPTH(PATTERN_VERTICES)) u_patt_ram (
    .clk  (clk),
    .we   (prow_we),
    .waddr(prow_waddr),
    .wdata(prow_wdata),
    .re   (prow_re),
    .raddr(prow_raddr),
    .rdata(prow_rdata)
  );

  emcc_ram #(.WIDTH(TARGET_VERTICES), .DEPTH(TARGET_VERTICES)) u_targ_ram (
    .clk  (clk),
    .we   (trow_we),
    .waddr(trow_waddr),
    .wdata(trow_wdata),
    .re   (trow_re),
    .raddr(trow_raddr),
    .rdata(trow_rdata)
  );

  // Row index range checks on the incoming request (row writes).
  assign fp_in_range_p = 7'(in_item.first_pattern) < 7'(PATTERN_VERTICES);
  assign fp_in_range_t = 7'(in_item.first_target) < 7'(TARGET_VERTICES);

  // Edge tests on the rows read at acceptance; they hold in the RAM output.
  // An endpoint out of range reads as no edge.
  assign p_edge = (7'(item_r.first_pattern) < 7'(PATTERN_VERTICES)) &&
                  (7'(item_r.second_pattern) < 7'(PATTERN_VERTICES)) &&
                  prow_rdata[item_r.second_pattern[PAW-1:0]];
  assign t_edge = (7'(item_r.first_target) < 7'(TARGET_VERTICES)) &&
                  (7'(item_r.second_target) < 7'(TARGET_VERTICES)) &&
                  trow_rdata[item_r.second_target[TAW-1:0]];

  // Same pattern vertex twice: the second read raced the first write, so
  // forward the binding the first endpoint left behind.
  assign sp_bound = (item_r.second_pattern == item_r.first_pattern) ?
                    item_r.first_target : map_rdata;

  always_comb begin
    state_nxt      = state_r;
    fail_nxt       = fail_r;
    valid_nxt      = valid_r;
    item_nxt       = item_r;
    out_strobe_nxt = 1'b0;

    map_we    = 1'b0;
    map_waddr = item_r.first_pattern;
    map_wdata = item_r.first_target;
    map_re    = 1'b0;
    map_raddr = in_item.first_pattern;

    prow_we    = 1'b0;
    prow_waddr = in_item.first_pattern[PAW-1:0];
    prow_wdata = in_item.row_bits[PATTERN_VERTICES-1:0];
    prow_re    = 1'b0;
    prow_raddr = in_item.first_pattern[PAW-1:0];

    trow_we    = 1'b0;
    trow_waddr = in_item.first_target[TAW-1:0];
    trow_wdata = in_item.row_bits[TARGET_VERTICES-1:0];
    trow_re    = 1'b0;
    trow_raddr = in_item.first_target[TAW-1:0];

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (in_item.op)
            OP_START: begin
              // Drop all bindings and clear the failure latch.
              fail_nxt       = CAUSE_NONE;
              valid_nxt      = '0;
              out_strobe_nxt = 1'b1;
            end
            OP_PATT_ROW: begin
              prow_we        = fp_in_range_p;
              out_strobe_nxt = 1'b1;
            end
            OP_TARG_ROW: begin
              trow_we        = fp_in_range_t;
              out_strobe_nxt = 1'b1;
            end
            OP_CHECK: begin
              if (fail_r != CAUSE_NONE) begin
                // Latched failure: repeat the cause, change nothing.
                out_strobe_nxt = 1'b1;
              end else begin
                // Fetch the first binding and both adjacency rows at once.
                item_nxt  = in_item;
                map_re    = 1'b1;
                prow_re   = 1'b1;
                trow_re   = 1'b1;
                state_nxt = ST_FIRST;
              end
            end
            default: begin
              out_strobe_nxt = 1'b1;
            end
          endcase
        end
      end

      ST_FIRST: begin
        if (valid_r[item_r.first_pattern] && (map_rdata != item_r.first_target)) begin
          fail_nxt       = CAUSE_FIRST;
          out_strobe_nxt = 1'b1;
          state_nxt      = ST_IDLE;
        end else begin
          if (!valid_r[item_r.first_pattern]) begin
            map_we                              = 1'b1;
            valid_nxt[item_r.first_pattern] = 1'b1;
          end
          // Advance to the second endpoint's binding.
          map_re    = 1'b1;
          map_raddr = item_r.second_pattern;
          state_nxt = ST_SECOND;
        end
      end

      ST_SECOND: begin
        if (valid_r[item_r.second_pattern] && (sp_bound != item_r.second_target)) begin
          fail_nxt = CAUSE_SECOND;
        end else begin
          if (!valid_r[item_r.second_pattern]) begin
            map_we                               = 1'b1;
            map_waddr                            = item_r.second_pattern;
            map_wdata                            = item_r.second_target;
            valid_nxt[item_r.second_pattern] = 1'b1;
          end
          if (!p_edge) begin
            fail_nxt = CAUSE_PATTERN_EDGE;
          end else if (!t_edge) begin
            fail_nxt = CAUSE_TARGET_EDGE;
          end
        end
        out_strobe_nxt = 1'b1;
        state_nxt      = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      fail_r       <= CAUSE_NONE;
      valid_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fail_r       <= fail_nxt;
      valid_r      <= valid_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Hold the request payload; no reset needed.
  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  // The latch only moves on acceptance or in the work states, so during a
  // strobe cycle it shows exactly the state the request left behind.
  assign busy                   = (state_r != ST_IDLE);
  assign out_strobe             = out_strobe_r;
  assign out_item.consistent    = (fail_r == CAUSE_NONE);
  assign out_item.failure_cause = fail_r;

endmodule
